// ----- hdl/mhd_pkg.sv -----
`default_nettype none

package mhd_pkg;

  // Angle and CORDIC word: signed Q4.60 radians in 64 bits
  localparam int CW = 64;
  localparam int FRAC_BITS = 60;
  localparam int ANGLE_STAGES = 24;

  // Input component widths
  localparam int MAG_IN_W = 16;
  localparam int COMP_W = MAG_IN_W + 1;
  localparam int SHIFT_W = 6;
  localparam logic [SHIFT_W-1:0] NORM_MSB = SHIFT_W'(FRAC_BITS - 1);

  // Degree scale 180 / 3.14159265 as the exact ratio NUM / DEN
  localparam int NUM_W = 32;
  localparam int DEN_W = 26;
  localparam logic [NUM_W-1:0] SCALE_NUM = 32'd3600000000;
  localparam logic [DEN_W-1:0] SCALE_DEN = 26'd62831853;

  // Angle magnitude and the split product m * NUM
  localparam int MAG_W = 62;
  localparam int MLO_W = 31;
  localparam int MHI_W = MAG_W - MLO_W;
  localparam int PROD_W = MLO_W + NUM_W;
  localparam int P_W = MAG_W + NUM_W;
  localparam int Q_W = P_W - FRAC_BITS;
  localparam logic [Q_W-1:0] SCALE_DEN_Q = Q_W'(SCALE_DEN);

  // Whole degrees of a half turn fit in DEG_BITS
  localparam int DEG_BITS = 8;
  localparam int HEAD_W = 9;
  localparam logic [HEAD_W-1:0] HALF_TURN_DEG = 9'd180;
  localparam logic [HEAD_W-1:0] FULL_TURN_DEG = 9'd360;

  // One CORDIC micro-rotation stage
  typedef struct packed {
    logic                 act;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] z;
  } cordic_t;

  // One step of the residual divider
  typedef struct packed {
    logic                 en;
    logic                 clamp;
    logic                 sub;
    logic [CW-1:0]        rem;
    logic [CW-1:0]        den;
    logic [FRAC_BITS-1:0] quo;
    logic signed [CW-1:0] z;
  } div_t;

  // Divide by the odd number 2k+1; elaboration only
  function automatic logic [CW-1:0] odd_div(input logic [CW-1:0] p, input int k);
    logic [CW-1:0] r;
    unique case (k)
      0:  r = p;
      1:  r = p / 3;
      2:  r = p / 5;
      3:  r = p / 7;
      4:  r = p / 9;
      5:  r = p / 11;
      6:  r = p / 13;
      7:  r = p / 15;
      8:  r = p / 17;
      9:  r = p / 19;
      10: r = p / 21;
      11: r = p / 23;
      12: r = p / 25;
      13: r = p / 27;
      14: r = p / 29;
      15: r = p / 31;
      16: r = p / 33;
      17: r = p / 35;
      18: r = p / 37;
      19: r = p / 39;
      20: r = p / 41;
      21: r = p / 43;
      22: r = p / 45;
      23: r = p / 47;
      24: r = p / 49;
      25: r = p / 51;
      26: r = p / 53;
      27: r = p / 55;
      28: r = p / 57;
      29: r = p / 59;
      30: r = p / 61;
      31: r = p / 63;
      default: r = '0;
    endcase
    return r;
  endfunction

  // atan(1/5) in Q60 by truncated series
  function automatic logic [CW-1:0] atan5_q60();
    logic [CW-1:0] p;
    logic [CW-1:0] sum;
    logic [CW-1:0] term;
    p = (64'd1 << FRAC_BITS) / 5;
    sum = '0;
    for (int k = 0; k < 32; k++) begin
      if (p != 0) begin
        term = odd_div(p, k);
        if ((k & 1) != 0) sum = sum - term;
        else sum = sum + term;
        p = p / 25;
      end
    end
    return sum;
  endfunction

  // atan(1/239) in Q60 by truncated series
  function automatic logic [CW-1:0] atan239_q60();
    logic [CW-1:0] p;
    logic [CW-1:0] sum;
    logic [CW-1:0] term;
    p = (64'd1 << FRAC_BITS) / 239;
    sum = '0;
    for (int k = 0; k < 32; k++) begin
      if (p != 0) begin
        term = odd_div(p, k);
        if ((k & 1) != 0) sum = sum - term;
        else sum = sum + term;
        p = p / 57121;
      end
    end
    return sum;
  endfunction

  // atan(1) by Machin's formula
  function automatic logic [CW-1:0] atan_one_q60();
    return (atan5_q60() << 2) - atan239_q60();
  endfunction

  // atan(2^-i) in Q60 for one CORDIC stage
  function automatic logic [CW-1:0] atan_pow2_q60(input int i);
    logic [CW-1:0] p;
    logic [CW-1:0] sum;
    logic [CW-1:0] term;
    if (i == 0) return atan_one_q60();
    if (i > FRAC_BITS) return '0;
    p = (64'd1 << FRAC_BITS) >> i;
    sum = '0;
    for (int k = 0; k < 32; k++) begin
      if (p != 0) begin
        term = odd_div(p, k);
        if ((k & 1) != 0) sum = sum - term;
        else sum = sum + term;
        p = (2 * i < CW) ? (p >> (2 * i)) : '0;
      end
    end
    return sum;
  endfunction

  localparam logic signed [CW-1:0] PI_Q60 = atan_one_q60() << 2;

endpackage

`default_nettype wire

// ----- hdl/mhd_cordic.sv -----
`default_nettype none

module mhd_cordic (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             vld_i,
  input  wire mhd_pkg::cordic_t data_i,
  output logic                  vld_o,
  output mhd_pkg::cordic_t      data_o
);

  logic             vld_q [mhd_pkg::ANGLE_STAGES];
  mhd_pkg::cordic_t stg_q [mhd_pkg::ANGLE_STAGES];

  for (genvar i = 0; i < mhd_pkg::ANGLE_STAGES; i++) begin : g_stage
    localparam logic signed [mhd_pkg::CW-1:0] Atan = mhd_pkg::atan_pow2_q60(i);

    mhd_pkg::cordic_t             prev;
    mhd_pkg::cordic_t             stg_d;
    logic                         prev_vld;
    logic signed [mhd_pkg::CW-1:0] cx_s;
    logic signed [mhd_pkg::CW-1:0] cy_s;
    logic signed [mhd_pkg::CW-1:0] z_s;
    logic signed [mhd_pkg::CW-1:0] dx;
    logic signed [mhd_pkg::CW-1:0] dy;

    if (i == 0) begin : g_first
      assign prev     = data_i;
      assign prev_vld = vld_i;
    end else begin : g_next
      assign prev     = stg_q[i-1];
      assign prev_vld = vld_q[i-1];
    end

    assign cx_s = prev.cx;
    assign cy_s = prev.cy;
    assign z_s  = prev.z;
    assign dx   = cy_s >>> i;
    assign dy   = cx_s >>> i;

    // Rotate toward the x axis; steer by the sign of y
    always_comb begin
      stg_d = prev;
      if (!cy_s[mhd_pkg::CW-1]) begin
        stg_d.cx = cx_s + dx;
        stg_d.cy = cy_s - dy;
        if (prev.act) stg_d.z = z_s + Atan;
      end else begin
        stg_d.cx = cx_s - dx;
        stg_d.cy = cy_s + dy;
        if (prev.act) stg_d.z = z_s - Atan;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) stg_q[i] <= stg_d;
    end
  end

  assign vld_o  = vld_q[mhd_pkg::ANGLE_STAGES-1];
  assign data_o = stg_q[mhd_pkg::ANGLE_STAGES-1];

endmodule

`default_nettype wire

// ----- hdl/mhd_resid_div.sv -----
`default_nettype none

module mhd_resid_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire mhd_pkg::div_t data_i,
  output logic               vld_o,
  output mhd_pkg::div_t      data_o
);

  logic          vld_q [mhd_pkg::FRAC_BITS];
  mhd_pkg::div_t stg_q [mhd_pkg::FRAC_BITS];

  for (genvar k = 0; k < mhd_pkg::FRAC_BITS; k++) begin : g_step
    mhd_pkg::div_t             prev;
    mhd_pkg::div_t             stg_d;
    logic                      prev_vld;
    logic [mhd_pkg::CW-1:0]    rem2;
    logic                      take;

    if (k == 0) begin : g_first
      assign prev     = data_i;
      assign prev_vld = vld_i;
    end else begin : g_next
      assign prev     = stg_q[k-1];
      assign prev_vld = vld_q[k-1];
    end

    // Restoring step: one quotient bit
    assign rem2 = {prev.rem[mhd_pkg::CW-2:0], 1'b0};
    assign take = rem2 >= prev.den;

    always_comb begin
      stg_d     = prev;
      stg_d.rem = take ? (rem2 - prev.den) : rem2;
      stg_d.quo = {prev.quo[mhd_pkg::FRAC_BITS-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) stg_q[k] <= stg_d;
    end
  end

  assign vld_o  = vld_q[mhd_pkg::FRAC_BITS-1];
  assign data_o = stg_q[mhd_pkg::FRAC_BITS-1];

endmodule

`default_nettype wire

// ----- hdl/magnetometer_heading_degrees.sv -----
// Depth: ANGLE_STAGES + FRAC_BITS + 17 register stages, 101 at the default sizes.
// Throughput: one sample per cycle while no finished result is blocked; every stage is a
//   register and the whole chain advances together.
// Reset: rst_ni clears every valid bit, the output valid included; data registers
//   are not reset.
`default_nettype none

module magnetometer_heading_degrees (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    x_high_byte_i,
  input  wire logic [7:0]                    x_low_byte_i,
  input  wire logic [7:0]                    y_high_byte_i,
  input  wire logic [7:0]                    y_low_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [mhd_pkg::HEAD_W-1:0]         heading_degrees_o
);

  typedef struct packed {
    logic                                 act;
    logic signed [mhd_pkg::COMP_W-1:0]    xv;
    logic signed [mhd_pkg::COMP_W-1:0]    yv;
    logic [mhd_pkg::MAG_IN_W-1:0]         mag;
    logic signed [mhd_pkg::CW-1:0]        z;
  } front_t;

  typedef struct packed {
    logic                       neg;
    logic [mhd_pkg::MHI_W-1:0]  mhi;
    logic [mhd_pkg::PROD_W-1:0] plo;
  } mul1_t;

  typedef struct packed {
    logic                       neg;
    logic [mhd_pkg::PROD_W-1:0] plo;
    logic [mhd_pkg::PROD_W-1:0] phi;
  } mul2_t;

  typedef struct packed {
    logic                         neg;
    logic                         lowfrac;
    logic [mhd_pkg::Q_W-1:0]      rem;
    logic [mhd_pkg::DEG_BITS-1:0] quo;
  } deg_t;

  logic en;
  logic last_vld;

  // Advance the chain unless a finished result would be blocked
  assign en         = !last_vld || !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------- Front end: join, fold left half plane ----------------
  logic signed [mhd_pkg::MAG_IN_W-1:0] x_s;
  logic signed [mhd_pkg::MAG_IN_W-1:0] y_s;
  logic signed [mhd_pkg::COMP_W-1:0]   xe;
  logic signed [mhd_pkg::COMP_W-1:0]   ye;
  logic signed [mhd_pkg::COMP_W-1:0]   ax;
  logic signed [mhd_pkg::COMP_W-1:0]   ay;
  front_t                              f1_d;
  front_t                              f1_q;
  logic                                f1_vld_q;

  assign x_s = {x_high_byte_i, x_low_byte_i};
  assign y_s = {y_high_byte_i, y_low_byte_i};
  assign xe  = {x_s[mhd_pkg::MAG_IN_W-1], x_s};
  assign ye  = {y_s[mhd_pkg::MAG_IN_W-1], y_s};
  assign ax  = xe[mhd_pkg::COMP_W-1] ? -xe : xe;
  assign ay  = ye[mhd_pkg::COMP_W-1] ? -ye : ye;

  always_comb begin
    f1_d.act = (y_s != '0);
    f1_d.mag = (ax > ay) ? ax[mhd_pkg::MAG_IN_W-1:0] : ay[mhd_pkg::MAG_IN_W-1:0];
    f1_d.xv  = xe;
    f1_d.yv  = ye;
    f1_d.z   = '0;
    if (y_s == '0) begin
      // On the x axis: angle is exact, rotation stages see a zero vector
      f1_d.xv = '0;
      f1_d.yv = '0;
      f1_d.z  = x_s[mhd_pkg::MAG_IN_W-1] ? mhd_pkg::PI_Q60 : '0;
    end else if (x_s[mhd_pkg::MAG_IN_W-1]) begin
      f1_d.xv = -xe;
      f1_d.yv = -ye;
      f1_d.z  = y_s[mhd_pkg::MAG_IN_W-1] ? -mhd_pkg::PI_Q60 : mhd_pkg::PI_Q60;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) f1_q <= f1_d;
  end

  // ---------------- Normalize the larger magnitude into [2^59, 2^60) ----------------
  logic [3:0]                   msb;
  logic [mhd_pkg::SHIFT_W-1:0]  sh;
  mhd_pkg::cordic_t             cin_d;
  mhd_pkg::cordic_t             cin_q;
  logic                         cin_vld_q;

  always_comb begin
    msb = '0;
    for (int b = 0; b < mhd_pkg::MAG_IN_W; b++) begin
      if (f1_q.mag[b]) msb = 4'(b);
    end
  end

  assign sh = mhd_pkg::NORM_MSB - {2'b00, msb};

  always_comb begin
    cin_d.act = f1_q.act;
    cin_d.cx  = {{(mhd_pkg::CW-mhd_pkg::COMP_W){f1_q.xv[mhd_pkg::COMP_W-1]}}, f1_q.xv} << sh;
    cin_d.cy  = {{(mhd_pkg::CW-mhd_pkg::COMP_W){f1_q.yv[mhd_pkg::COMP_W-1]}}, f1_q.yv} << sh;
    cin_d.z   = f1_q.z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cin_vld_q <= 1'b0;
    end else if (en) begin
      cin_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) cin_q <= cin_d;
  end

  // ---------------- CORDIC vectoring ----------------
  mhd_pkg::cordic_t cor_out;
  logic             cor_vld;

  mhd_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (cin_vld_q),
    .data_i (cin_q),
    .vld_o  (cor_vld),
    .data_o (cor_out)
  );

  // ---------------- Residual correction setup ----------------
  logic [mhd_pkg::CW-1:0] cy_abs;
  mhd_pkg::div_t          din_d;
  mhd_pkg::div_t          din_q;
  logic                   din_vld_q;

  assign cy_abs = cor_out.cy[mhd_pkg::CW-1] ? -cor_out.cy : cor_out.cy;

  always_comb begin
    din_d.en    = !cor_out.cx[mhd_pkg::CW-1] && (cor_out.cx != '0) && (cor_out.cy != '0);
    din_d.clamp = cy_abs >= cor_out.cx;
    din_d.sub   = cor_out.cy[mhd_pkg::CW-1];
    din_d.rem   = cy_abs;
    din_d.den   = cor_out.cx;
    din_d.quo   = '0;
    din_d.z     = cor_out.z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      din_vld_q <= 1'b0;
    end else if (en) begin
      din_vld_q <= cor_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) din_q <= din_d;
  end

  mhd_pkg::div_t dv_out;
  logic          dv_vld;

  mhd_resid_div u_resid_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (din_vld_q),
    .data_i (din_q),
    .vld_o  (dv_vld),
    .data_o (dv_out)
  );

  // ---------------- Apply the residual to the angle ----------------
  logic [mhd_pkg::CW-1:0]        qx;
  logic signed [mhd_pkg::CW-1:0] zf_d;
  logic signed [mhd_pkg::CW-1:0] zf_q;
  logic                          zf_vld_q;

  always_comb begin
    qx = '0;
    if (dv_out.en) begin
      if (dv_out.clamp) qx[mhd_pkg::FRAC_BITS] = 1'b1;
      else qx = {{(mhd_pkg::CW-mhd_pkg::FRAC_BITS){1'b0}}, dv_out.quo};
    end
  end

  assign zf_d = dv_out.sub ? (dv_out.z - $signed(qx)) : (dv_out.z + $signed(qx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zf_vld_q <= 1'b0;
    end else if (en) begin
      zf_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) zf_q <= zf_d;
  end

  // ---------------- Angle magnitude ----------------
  logic [mhd_pkg::CW-1:0]    zf_neg;
  logic                      mg_neg_q;
  logic [mhd_pkg::MAG_W-1:0] mg_q;
  logic                      mg_vld_q;

  assign zf_neg = -zf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mg_vld_q <= 1'b0;
    end else if (en) begin
      mg_vld_q <= zf_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mg_neg_q <= zf_q[mhd_pkg::CW-1];
      mg_q     <= zf_q[mhd_pkg::CW-1] ? zf_neg[mhd_pkg::MAG_W-1:0] : zf_q[mhd_pkg::MAG_W-1:0];
    end
  end

  // ---------------- Degree scale: low partial product ----------------
  mul1_t m1_d;
  mul1_t m1_q;
  logic  m1_vld_q;

  always_comb begin
    m1_d.neg = mg_neg_q;
    m1_d.mhi = mg_q[mhd_pkg::MAG_W-1:mhd_pkg::MLO_W];
    m1_d.plo = {{(mhd_pkg::PROD_W-mhd_pkg::MLO_W){1'b0}}, mg_q[mhd_pkg::MLO_W-1:0]}
             * {{(mhd_pkg::PROD_W-mhd_pkg::NUM_W){1'b0}}, mhd_pkg::SCALE_NUM};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else if (en) begin
      m1_vld_q <= mg_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) m1_q <= m1_d;
  end

  // ---------------- Degree scale: high partial product ----------------
  mul2_t m2_d;
  mul2_t m2_q;
  logic  m2_vld_q;

  always_comb begin
    m2_d.neg = m1_q.neg;
    m2_d.plo = m1_q.plo;
    m2_d.phi = {{(mhd_pkg::PROD_W-mhd_pkg::MHI_W){1'b0}}, m1_q.mhi}
             * {{(mhd_pkg::PROD_W-mhd_pkg::NUM_W){1'b0}}, mhd_pkg::SCALE_NUM};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else if (en) begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) m2_q <= m2_d;
  end

  // ---------------- Join the product, drop the angle fraction ----------------
  logic [mhd_pkg::P_W-1:0] prod;
  deg_t                    sm_d;
  deg_t                    sm_q;
  logic                    sm_vld_q;

  assign prod = {m2_q.phi, {mhd_pkg::MLO_W{1'b0}}}
              + {{(mhd_pkg::P_W-mhd_pkg::PROD_W){1'b0}}, m2_q.plo};

  always_comb begin
    sm_d.neg     = m2_q.neg;
    sm_d.lowfrac = |prod[mhd_pkg::FRAC_BITS-1:0];
    sm_d.rem     = prod[mhd_pkg::P_W-1:mhd_pkg::FRAC_BITS];
    sm_d.quo     = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_vld_q <= 1'b0;
    end else if (en) begin
      sm_vld_q <= m2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) sm_q <= sm_d;
  end

  // ---------------- Divide by the scale denominator, one bit a stage ----------------
  deg_t dg_q     [mhd_pkg::DEG_BITS];
  logic dg_vld_q [mhd_pkg::DEG_BITS];

  for (genvar j = 0; j < mhd_pkg::DEG_BITS; j++) begin : g_deg
    localparam int Bit = mhd_pkg::DEG_BITS - 1 - j;
    localparam logic [mhd_pkg::Q_W-1:0] DenSh = mhd_pkg::SCALE_DEN_Q << Bit;

    deg_t prev;
    deg_t dg_d;
    logic prev_vld;

    if (j == 0) begin : g_first
      assign prev     = sm_q;
      assign prev_vld = sm_vld_q;
    end else begin : g_next
      assign prev     = dg_q[j-1];
      assign prev_vld = dg_vld_q[j-1];
    end

    always_comb begin
      dg_d = prev;
      if (prev.rem >= DenSh) begin
        dg_d.rem      = prev.rem - DenSh;
        dg_d.quo[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dg_vld_q[j] <= 1'b0;
      end else if (en) begin
        dg_vld_q[j] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) dg_q[j] <= dg_d;
    end
  end

  assign last_vld = dg_vld_q[mhd_pkg::DEG_BITS-1];

  // ---------------- Offset by a half turn, truncate toward zero ----------------
  deg_t                        dg_last;
  logic                        frac;
  logic [mhd_pkg::HEAD_W-1:0]  fl;
  logic [mhd_pkg::HEAD_W-1:0]  pos_sum;
  logic [mhd_pkg::HEAD_W-1:0]  neg_c;
  logic [mhd_pkg::HEAD_W-1:0]  head_d;
  logic [mhd_pkg::HEAD_W-1:0]  head_q;
  logic                        out_vld_q;
  logic                        out_load;

  assign dg_last = dg_q[mhd_pkg::DEG_BITS-1];
  assign frac    = dg_last.lowfrac || (dg_last.rem != '0);
  assign fl      = {{(mhd_pkg::HEAD_W-mhd_pkg::DEG_BITS){1'b0}}, dg_last.quo};
  assign pos_sum = mhd_pkg::HALF_TURN_DEG + fl;
  assign neg_c   = fl + {{(mhd_pkg::HEAD_W-1){1'b0}}, frac};

  always_comb begin
    if (!dg_last.neg) begin
      head_d = (pos_sum > mhd_pkg::FULL_TURN_DEG) ? mhd_pkg::FULL_TURN_DEG : pos_sum;
    end else begin
      head_d = (neg_c >= mhd_pkg::HALF_TURN_DEG) ? '0 : (mhd_pkg::HALF_TURN_DEG - neg_c);
    end
  end

  // Hold the result until the transfer completes
  assign out_load = last_vld && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) head_q <= head_d;
  end

  assign out_valid_o       = out_vld_q;
  assign heading_degrees_o = head_q;

endmodule

`default_nettype wire

// ----- hdl/mhd_checker.sv -----
`default_nettype none

module mhd_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [mhd_pkg::HEAD_W-1:0]    heading_degrees_o
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(heading_degrees_o))
    else $error("stalled heading changed or dropped");

  // Headings never leave a full turn
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heading_degrees_o <= mhd_pkg::FULL_TURN_DEG)
    else $error("heading above 360");

  // Input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with the output free");

  // Leave reset with the output valid low and the input free
  a_reset_clear: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("state survives reset");

endmodule

bind magnetometer_heading_degrees mhd_checker u_mhd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .heading_degrees_o (heading_degrees_o)
);

`default_nettype wire
